@@ rtl/ptc_pkg.sv @@
// Shared types, constants and helpers for the pressure/temperature compensation block.
package ptc_pkg;

  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int DIV_STEPS      = 64;
  localparam int DEN_W          = 31;

  localparam logic signed [33:0] OFFSET_T = 34'sd128000;
  localparam logic [11:0]        SCALE_P  = 12'd3125;
  localparam logic [63:0]        RAW_FULL = 64'd1048576;
  localparam logic [31:0]        T_MUL    = 32'd5;
  localparam logic [31:0]        T_ROUND  = 32'd128;
  localparam logic [63:0]        W_BIAS   = 64'h0000_8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_T1    = 4'd0,
    REG_CAL_T2    = 4'd1,
    REG_CAL_T3    = 4'd2,
    REG_CAL_P1    = 4'd3,
    REG_CAL_P2_P3 = 4'd4,
    REG_CAL_P4_P5 = 4'd5,
    REG_CAL_P6_P7 = 4'd6,
    REG_CAL_P8_P9 = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // queue entry: magnitudes and quotient sign for the divider, zero-divisor flag, temperature
  typedef struct packed {
    logic [63:0]      mn;
    logic [DEN_W-1:0] md;
    logic             neg;
    logic             bad;
    logic [15:0]      tc;
  } dq_t;

  function automatic logic [63:0] sx16_64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx16_32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ rtl/ptc_if.sv @@
// Handshake channel interfaces: sample input, result output, calibration writes.
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  modport source(output valid, raw_pressure, raw_temperature, input ready);
  modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               pressure_invalid;
  modport source(output valid, temperature_centi, pressure_q24_8, pressure_invalid,
                 input ready);
  modport sink(input valid, temperature_centi, pressure_q24_8, pressure_invalid,
               output ready);
endinterface

interface ptc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]    index;
  logic [ptc_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/ptc_cfg_regs.sv @@
// Calibration register file written through the configuration channel.
module ptc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  ptc_cfg_if.sink       cfg_ch,
  output ptc_pkg::cal_t cal
);
  import ptc_pkg::*;

  cal_t cal_r;

  assign cfg_ch.ready = 1'b1;
  assign cal = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CAL_T1: cal_r.t1 <= cfg_ch.data[15:0];
        REG_CAL_T2: cal_r.t2 <= cfg_ch.data[15:0];
        REG_CAL_T3: cal_r.t3 <= cfg_ch.data[15:0];
        REG_CAL_P1: cal_r.p1 <= cfg_ch.data[15:0];
        REG_CAL_P2_P3: begin
          cal_r.p2 <= cfg_ch.data[31:16];
          cal_r.p3 <= cfg_ch.data[15:0];
        end
        REG_CAL_P4_P5: begin
          cal_r.p4 <= cfg_ch.data[31:16];
          cal_r.p5 <= cfg_ch.data[15:0];
        end
        REG_CAL_P6_P7: begin
          cal_r.p6 <= cfg_ch.data[31:16];
          cal_r.p7 <= cfg_ch.data[15:0];
        end
        REG_CAL_P8_P9: begin
          cal_r.p8 <= cfg_ch.data[31:16];
          cal_r.p9 <= cfg_ch.data[15:0];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ptc_front.sv @@
// Front pipeline: temperature path, pressure numerator/divisor, zero-divisor classification.
module ptc_front (
  input  logic          clk,
  input  logic          rst_n,
  ptc_in_if.sink        in_ch,
  input  ptc_pkg::cal_t cal,
  output logic          q_valid,
  input  logic          q_ready,
  output ptc_pkg::dq_t  q_item
);
  import ptc_pkg::*;

  localparam int NF = 14;

  logic en;
  logic vld_r [1:NF];
  logic [19:0] adcp_r [1:10];
  logic [15:0] tc_r [5:NF];

  logic [31:0] apre_r, d_r, am_r, dd_r, a_r, bm_r, tf_r;
  logic signed [33:0] v1_r;
  logic signed [33:0] hh_r;
  logic signed [34:0] hl_r;
  logic [33:0] ll_r;
  logic signed [49:0] v1p5_r [6:9];
  logic signed [49:0] v1p2_r [6:9];
  logic [63:0] sq_r;
  logic signed [48:0] m6lo_r, m3lo_r;
  logic [31:0] m6hi_r, m3hi_r;
  logic [63:0] s6_r, s3_r, v2_r, v1b_r, x_r, w_r, num_r;
  logic [43:0] xl_r;
  logic [31:0] xh_r, wh_r;
  logic [47:0] wl_r;
  logic [DEN_W-1:0] den_r;
  dq_t item_r;

  logic [31:0] adct, t1x, t2x, t3x, p6x, p3x, bms, dds, tmul;
  logic signed [16:0] h;
  logic [16:0] l;
  logic signed [32:0] sqlo;
  logic signed [15:0] p2s, p3s, p5s, p6s;
  logic [63:0] s3sar, prx, wsum;
  logic signed [31:0] am_s, bm_s, dd_s;
  logic signed [63:0] s3_s;

  assign en = !vld_r[NF] || q_ready;
  assign in_ch.ready = en;
  assign q_valid = vld_r[NF];
  assign q_item = item_r;

  always_comb begin
    adct  = {12'b0, in_ch.raw_temperature};
    t1x   = {16'b0, cal.t1};
    t2x   = sx16_32(cal.t2);
    t3x   = sx16_32(cal.t3);
    p6x   = sx16_32(cal.p6);
    p3x   = sx16_32(cal.p3);
    p2s   = cal.p2;
    p3s   = cal.p3;
    p5s   = cal.p5;
    p6s   = cal.p6;
    am_s  = $signed(am_r);
    dd_s  = $signed(dd_r);
    bm_s  = $signed(bm_r);
    dds   = dd_s >>> 12;
    bms   = bm_s >>> 14;
    tmul  = tf_r * T_MUL + T_ROUND;
    h     = v1_r[33:17];
    l     = v1_r[16:0];
    sqlo  = $signed({1'b0, sq_r[31:0]});
    s3_s  = $signed(s3_r);
    s3sar = s3_s >>> 8;
    prx   = RAW_FULL - {44'b0, adcp_r[10]};
    wsum  = {16'b0, wl_r} + {wh_r, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NF; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_ch.valid;
      for (int i = 2; i <= NF; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adcp_r[1] <= in_ch.raw_pressure;
      for (int i = 2; i <= 10; i++) adcp_r[i] <= adcp_r[i-1];
      tc_r[5] <= tmul[23:8];
      for (int i = 6; i <= NF; i++) tc_r[i] <= tc_r[i-1];
      // temperature
      apre_r <= (adct >> 3) - (t1x << 1);
      d_r    <= (adct >> 4) - t1x;
      am_r   <= apre_r * t2x;
      dd_r   <= d_r * d_r;
      a_r    <= am_s >>> 11;
      bm_r   <= dds * t3x;
      tf_r   <= a_r + bms;
      // pressure terms
      v1_r      <= $signed({{2{tf_r[31]}}, tf_r}) - OFFSET_T;
      hh_r      <= 34'(h) * 34'(h);
      hl_r      <= 35'(h) * 35'($signed({1'b0, l}));
      ll_r      <= 34'(l) * 34'(l);
      v1p5_r[6] <= 50'(v1_r) * 50'(p5s);
      v1p2_r[6] <= 50'(v1_r) * 50'(p2s);
      for (int i = 7; i <= 9; i++) begin
        v1p5_r[i] <= v1p5_r[i-1];
        v1p2_r[i] <= v1p2_r[i-1];
      end
      sq_r   <= ({{30{hh_r[33]}}, hh_r} << 34) + ({{29{hl_r[34]}}, hl_r} << 18)
                + {30'b0, ll_r};
      m6lo_r <= 49'(sqlo) * 49'(p6s);
      m6hi_r <= sq_r[63:32] * p6x;
      m3lo_r <= 49'(sqlo) * 49'(p3s);
      m3hi_r <= sq_r[63:32] * p3x;
      s6_r   <= {{15{m6lo_r[48]}}, m6lo_r} + {m6hi_r, 32'b0};
      s3_r   <= {{15{m3lo_r[48]}}, m3lo_r} + {m3hi_r, 32'b0};
      v2_r   <= s6_r + ({{14{v1p5_r[9][49]}}, v1p5_r[9]} << 17) + (sx16_64(cal.p4) << 35);
      v1b_r  <= s3sar + ({{14{v1p2_r[9][49]}}, v1p2_r[9]} << 12);
      x_r    <= (prx << 31) - v2_r;
      w_r    <= W_BIAS + v1b_r;
      xl_r   <= 44'(x_r[31:0]) * 44'(SCALE_P);
      xh_r   <= x_r[63:32] * SCALE_P;
      wl_r   <= 48'(w_r[31:0]) * 48'(cal.p1);
      wh_r   <= w_r[63:32] * cal.p1;
      num_r  <= {20'b0, xl_r} + {xh_r, 32'b0};
      den_r  <= wsum[63:33];
      // split into magnitudes and signs
      item_r.mn  <= num_r[63] ? (64'd0 - num_r) : num_r;
      item_r.md  <= den_r[DEN_W-1] ? (DEN_W'(0) - den_r) : den_r;
      item_r.neg <= num_r[63] ^ den_r[DEN_W-1];
      item_r.bad <= (den_r == '0);
      item_r.tc  <= tc_r[NF-1];
    end
  end

endmodule

@@ rtl/ptc_queue.sv @@
// Small FIFO between front and back pipelines.
module ptc_queue #(
  parameter int DEPTH = ptc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  ptc_pkg::dq_t push_item,
  output logic         pop_valid,
  input  logic         pop_ready,
  output ptc_pkg::dq_t pop_item
);
  import ptc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dq_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

@@ rtl/ptc_back.sv @@
// Back pipeline: bit-per-stage divider, pressure correction terms, output register.
module ptc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ptc_pkg::cal_t cal,
  input  logic          q_valid,
  output logic          q_ready,
  input  ptc_pkg::dq_t  q_item,
  ptc_out_if.source     out_ch
);
  import ptc_pkg::*;

  localparam int NB = DIV_STEPS + 6;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [63:0]      nq;
    logic [DEN_W-1:0] md;
    logic             neg;
    logic             bad;
    logic [15:0]      tc;
  } div_t;

  logic en;
  logic vld_r [0:NB-1];
  div_t div_r [0:DIV_STEPS];

  logic [63:0] pc_r [0:4];
  logic        bad_r [0:4];
  logic [15:0] tc_r [0:4];
  logic [63:0] e2_r [2:4];
  logic [63:0] ll_r, qq_r, e1_r;
  logic [31:0] lh_r, phi_r, m9hi_r;
  logic signed [48:0] plo_r, m9lo_r;

  logic out_valid_r, bad_out_r;
  logic [15:0] tc_out_r;
  logic [31:0] pq_out_r;

  logic [31:0] ql, p8x, p9x, qhx, p7x;
  logic signed [15:0] p8s, p9s;
  logic signed [63:0] e2s, e1s;
  logic [63:0] e2sum, e1sum, fsum, qn;

  assign en = !out_valid_r || out_ch.ready;
  assign q_ready = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.temperature_centi = tc_out_r;
  assign out_ch.pressure_q24_8 = pq_out_r;
  assign out_ch.pressure_invalid = bad_out_r;

  always_comb begin
    qn    = div_r[DIV_STEPS].nq;
    ql    = pc_r[0][44:13];
    qhx   = {{13{pc_r[0][63]}}, pc_r[0][63:45]};
    p8x   = sx16_32(cal.p8);
    p9x   = sx16_32(cal.p9);
    p7x   = sx16_32(cal.p7);
    p8s   = cal.p8;
    p9s   = cal.p9;
    e2sum = {{15{plo_r[48]}}, plo_r} + {phi_r, 32'b0};
    e2s   = $signed(e2sum);
    e1sum = {{15{m9lo_r[48]}}, m9lo_r} + {m9hi_r, 32'b0};
    e1s   = $signed(e1sum);
    fsum  = pc_r[4] + e1_r + e2_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= q_valid;
      for (int i = 1; i < NB; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0].rem <= '0;
      div_r[0].nq  <= q_item.mn;
      div_r[0].md  <= q_item.md;
      div_r[0].neg <= q_item.neg;
      div_r[0].bad <= q_item.bad;
      div_r[0].tc  <= q_item.tc;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0] trial, diff;
    logic take;
    assign trial = {div_r[k].rem, div_r[k].nq[63]};
    assign diff  = trial - {1'b0, div_r[k].md};
    assign take  = (trial >= {1'b0, div_r[k].md});
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k+1].rem <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        div_r[k+1].nq  <= {div_r[k].nq[62:0], take};
        div_r[k+1].md  <= div_r[k].md;
        div_r[k+1].neg <= div_r[k].neg;
        div_r[k+1].bad <= div_r[k].bad;
        div_r[k+1].tc  <= div_r[k].tc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r[0]  <= div_r[DIV_STEPS].neg ? (64'd0 - qn) : qn;
      bad_r[0] <= div_r[DIV_STEPS].bad;
      tc_r[0]  <= div_r[DIV_STEPS].tc;
      for (int i = 1; i <= 4; i++) begin
        pc_r[i]  <= pc_r[i-1];
        bad_r[i] <= bad_r[i-1];
        tc_r[i]  <= tc_r[i-1];
      end
      // square of p>>13 and the P8 product
      ll_r   <= {32'b0, ql} * {32'b0, ql};
      lh_r   <= ql * qhx;
      plo_r  <= 49'($signed({1'b0, pc_r[0][31:0]})) * 49'(p8s);
      phi_r  <= pc_r[0][63:32] * p8x;
      qq_r   <= ll_r + {lh_r[30:0], 33'b0};
      e2_r[2] <= e2s >>> 19;
      m9lo_r <= 49'($signed({1'b0, qq_r[31:0]})) * 49'(p9s);
      m9hi_r <= qq_r[63:32] * p9x;
      e2_r[3] <= e2_r[2];
      e1_r   <= e1s >>> 25;
      e2_r[4] <= e2_r[3];
      // output register
      tc_out_r  <= tc_r[4];
      bad_out_r <= bad_r[4];
      pq_out_r  <= bad_r[4] ? 32'd0 : (fsum[39:8] + (p7x << 4));
    end
  end

endmodule

@@ rtl/pressure_temperature_compensation.sv @@
// Top level: calibration registers, front pipeline, queue and back pipeline.
// An accepted input passes through the front pipeline, the queue and the back pipeline to the result.
// Throughput one item per cycle while nothing stalls: every stage, including the 64-stage divider, is pipelined.
// A stalled output stalls the back pipeline; the queue lets the front keep running until the queue fills.
// Synchronous active-low reset clears calibration to zero and empties all pipelines.
module pressure_temperature_compensation #(
  parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptc_in_if.sink     in_ch,
  ptc_out_if.source  out_ch,
  ptc_cfg_if.sink    cfg_ch
);
  import ptc_pkg::*;

  cal_t cal;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  dq_t  fq_item, bq_item;

  ptc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cal    (cal)
  );

  ptc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cal     (cal),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_item   (bq_item)
  );

  ptc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .q_valid (bq_valid),
    .q_ready (bq_ready),
    .q_item  (bq_item),
    .out_ch  (out_ch)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for pressure_temperature_compensation: directed and random stimulus.
module testbench;
  import ptc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 4'd15;

  typedef struct {
    logic [15:0] tc;
    logic [31:0] pq;
    logic        bad;
  } reading_t;

  typedef struct {
    logic [19:0] rp;
    logic [19:0] rt;
    bit          typed;
    reading_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  ptc_in_if  in_if();
  ptc_out_if out_if();
  ptc_cfg_if cfg_if();

  pressure_temperature_compensation dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cal_t     cal;
  reading_t pending[$];
  int       errors = 0;
  int       cycles = 0;
  bit       no_gaps = 0;
  bit       hold_req = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic void apply_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_CAL_T1:    cal.t1 = val[15:0];
      REG_CAL_T2:    cal.t2 = val[15:0];
      REG_CAL_T3:    cal.t3 = val[15:0];
      REG_CAL_P1:    cal.p1 = val[15:0];
      REG_CAL_P2_P3: {cal.p2, cal.p3} = val;
      REG_CAL_P4_P5: {cal.p4, cal.p5} = val;
      REG_CAL_P6_P7: {cal.p6, cal.p7} = val;
      REG_CAL_P8_P9: {cal.p8, cal.p9} = val;
      default: ;
    endcase
  endfunction

  function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt);
    logic signed [31:0] at, t1, t2, t3, a, d, b, tf, tcw;
    logic signed [63:0] v1, v2, p, q, e1, e2, num, rp64;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] mn, md, qu;
    reading_t r;
    at = {12'd0, rt};
    t1 = {16'd0, cal.t1};
    t2 = 32'(cal.t2);
    t3 = 32'(cal.t3);
    a = ((at >>> 3) - (t1 <<< 1)) * t2;
    a = a >>> 11;
    d = (at >>> 4) - t1;
    b = (d * d) >>> 12;
    b = (b * t3) >>> 14;
    tf = a + b;
    tcw = (tf * 32'sd5 + 32'sd128) >>> 8;
    r.tc = tcw[15:0];
    p1 = {48'd0, cal.p1};
    p2 = 64'(cal.p2); p3 = 64'(cal.p3); p4 = 64'(cal.p4); p5 = 64'(cal.p5);
    p6 = 64'(cal.p6); p7 = 64'(cal.p7); p8 = 64'(cal.p8); p9 = 64'(cal.p9);
    v1 = 64'(tf);
    v1 = v1 - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = ((64'sh0000_8000_0000_0000 + v1) * p1) >>> 33;
    r.pq = '0;
    r.bad = (v1 == 0);
    if (!r.bad) begin
      rp64 = {44'd0, rp};
      p = 64'sd1048576 - rp64;
      num = ((p <<< 31) - v2) * 64'sd3125;
      mn = num[63] ? -num : num;
      md = v1[63] ? -v1 : v1;
      qu = mn / md;
      p = (num[63] != v1[63]) ? -qu : qu;
      q = p >>> 13;
      e1 = (p9 * q * q) >>> 25;
      e2 = (p8 * p) >>> 19;
      p = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
      r.pq = p[31:0];
    end
    return r;
  endfunction

  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    bit acc;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk);
      acc = cfg_if.ready;
      @(posedge clk);
    end while (!acc);
    apply_cal(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [19:0] rp, logic [19:0] rt, bit typed, reading_t want);
    int gap;
    bit acc;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.raw_pressure <= rp;
    in_if.raw_temperature <= rt;
    do begin
      @(negedge clk);
      acc = in_if.ready;
      @(posedge clk);
    end while (!acc);
    pending.push_back(typed ? want : compensate(rp, rt));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_cal(logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7);
    write_cal(REG_CAL_T1, w0);
    write_cal(REG_CAL_T2, w1);
    write_cal(REG_CAL_T3, w2);
    write_cal(REG_CAL_P1, w3);
    write_cal(REG_CAL_P2_P3, w4);
    write_cal(REG_CAL_P4_P5, w5);
    write_cal(REG_CAL_P6_P7, w6);
    write_cal(REG_CAL_P8_P9, w7);
  endtask

  // result checker
  always @(negedge clk) begin
    reading_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending.size() == 0) begin
        $error("unexpected item: tc=%0d pq=%h bad=%b", out_if.temperature_centi,
               out_if.pressure_q24_8, out_if.pressure_invalid);
        errors++;
      end else begin
        w = pending.pop_front();
        if (out_if.temperature_centi !== w.tc) begin
          $error("temperature_centi: expected %h, got %h", w.tc, out_if.temperature_centi);
          errors++;
        end
        if (out_if.pressure_q24_8 !== w.pq) begin
          $error("pressure_q24_8: expected %h, got %h", w.pq, out_if.pressure_q24_8);
          errors++;
        end
        if (out_if.pressure_invalid !== w.bad) begin
          $error("pressure_invalid: expected %b, got %b", w.bad, out_if.pressure_invalid);
          errors++;
        end
      end
    end
  end

  // result consumer; long hold-off on request
  initial begin
    int stall;
    bit acc;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do begin
        @(negedge clk);
        acc = out_if.valid;
        @(posedge clk);
      end while (!acc && !hold_req);
    end
  end

  row_t     rows[$];
  reading_t blank;
  logic [31:0] w[8];

  initial begin
    rst_n = 1'b0;
    in_if.valid <= 1'b0;
    in_if.raw_pressure <= '0;
    in_if.raw_temperature <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    cal = '0;
    blank = '{tc: 16'h0, pq: 32'h0, bad: 1'b1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration cleared: zero temperature, divisor zero
    rows = '{
      '{20'h00000, 20'h00000, 1, blank},
      '{20'hFFFFF, 20'hFFFFF, 1, blank},
      '{20'h00000, 20'hFFFFF, 1, blank},
      '{20'hFFFFF, 20'h00000, 1, blank}
    };
    foreach (rows[i]) send_sample(rows[i].rp, rows[i].rt, rows[i].typed, rows[i].want);
    drain();

    // typical sensor calibration; spare indexes must be ignored
    load_cal(32'd27504, 32'd26435, 32'h0000FC18, 32'd36477,
             {16'hD643, 16'd3024}, {16'd2855, 16'd140},
             {16'hFFF9, 16'd15500}, {16'hC6F8, 16'd6000});
    write_cal(IDX_SPARE_LO, 32'hFFFF_FFFF);
    write_cal(IDX_SPARE_HI, 32'h1234_5678);
    rows = '{
      '{20'd415148, 20'd519888, 0, blank},
      '{20'h00000, 20'h00000, 0, blank},
      '{20'hFFFFF, 20'hFFFFF, 0, blank},
      '{20'h00000, 20'hFFFFF, 0, blank},
      '{20'hFFFFF, 20'h00000, 0, blank},
      '{20'h80000, 20'h80000, 0, blank},
      '{20'h7FFFF, 20'h7FFFF, 0, blank},
      '{20'h55555, 20'hAAAAA, 0, blank}
    };
    foreach (rows[i]) send_sample(rows[i].rp, rows[i].rt, rows[i].typed, rows[i].want);
    drain();

    // extreme calibration words
    load_cal(32'hFFFF, 32'h7FFF, 32'h8000, 32'hFFFF,
             32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000, 32'h7FFF_7FFF);
    rows = '{
      '{20'h00000, 20'h00000, 0, blank},
      '{20'hFFFFF, 20'hFFFFF, 0, blank},
      '{20'h12345, 20'hEDCBA, 0, blank}
    };
    foreach (rows[i]) send_sample(rows[i].rp, rows[i].rt, rows[i].typed, rows[i].want);
    drain();
    load_cal(32'h0000, 32'h8000, 32'h7FFF, 32'h0001,
             32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_7FFF, 32'h8000_8000);
    send_sample(20'hFFFFF, 20'h00000, 0, blank);
    send_sample(20'h00000, 20'hFFFFF, 0, blank);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        foreach (w[k]) w[k] = $urandom();
      end else begin
        w[0] = 27504 + $urandom_range(0, 4000) - 2000;
        w[1] = 26435 + $urandom_range(0, 2000) - 1000;
        w[2] = 16'hFC18 + $urandom_range(0, 200);
        w[3] = 36477 + $urandom_range(0, 4000) - 2000;
        w[4] = {16'hD643 + 16'($urandom_range(0, 300)), 16'd3024 + 16'($urandom_range(0, 300))};
        w[5] = {16'd2855 + 16'($urandom_range(0, 300)), 16'd140 + 16'($urandom_range(0, 50))};
        w[6] = {16'hFFF9 + 16'($urandom_range(0, 14)), 16'd15500 + 16'($urandom_range(0, 500))};
        w[7] = {16'hC6F8 + 16'($urandom_range(0, 500)), 16'd6000 + 16'($urandom_range(0, 500))};
      end
      if (ph == 5) w[3] = 32'h0;
      load_cal(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]);
      write_cal(4'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), $urandom());
      no_gaps = (ph % 2 == 1);
      if (ph == 3) hold_req = 1;
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_sample(20'($urandom()), 20'($urandom()), 0, blank);
        else
          send_sample(20'($urandom_range(250000, 600000)), 20'($urandom_range(400000, 650000)),
                      0, blank);
      end
      no_gaps = 0;
      drain();
    end

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ptc_pkg.sv
rtl/ptc_if.sv
rtl/ptc_cfg_regs.sv
rtl/ptc_front.sv
rtl/ptc_queue.sv
rtl/ptc_back.sv
rtl/pressure_temperature_compensation.sv
bench/testbench.sv
